// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset.
`define BBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("check failed");

// Same, on the usual clock and reset names.
`define BBA_ASSERT_STD(lbl, prop) \
  `BBA_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/bba_pkg.sv -----
// Shared constants and payload types of the buddy block allocator.
`default_nettype none
package bba_pkg;

  localparam int unsigned MAX_LEVELS = 7;
  localparam int unsigned LEAF_BYTES = 16;
  localparam int unsigned NODE_COUNT = (2 << MAX_LEVELS) - 1;
  localparam int unsigned NODE_AW    = MAX_LEVELS + 1;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned POS_W      = MAX_LEVELS;

  // node codes
  localparam logic [1:0] ND_FREE  = 2'd0;
  localparam logic [1:0] ND_USED  = 2'd1;
  localparam logic [1:0] ND_SPLIT = 2'd2;
  localparam logic [1:0] ND_FULL  = 2'd3;

  // result codes
  localparam logic [1:0] RS_OK       = 2'd0;
  localparam logic [1:0] RS_ZERO     = 2'd1;
  localparam logic [1:0] RS_NO_SPACE = 2'd2;
  localparam logic [1:0] RS_BAD_OFFS = 2'd3;

  // register index
  localparam logic REG_TREE_LEVELS = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [11:0] request_size;
    logic [10:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] alloc_offset;
    logic [11:0] remaining_bytes;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/bba_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/buddy_block_allocator.sv -----
// Buddy block allocator: top level with the node-status memory sequencer.
//
// Requests come in on in_valid_i/in_ready_o as one word (mode, size, offset).
// Each request gives exactly one result word on out_valid_o/out_ready_i:
// a status, the byte offset of a new block and the free bytes left.
// The block serves one request at a time. The node-status tree sits in one
// two-bit memory with a registered read, and every step of a request is a
// read or a write of that memory:
//   zero size or too large: no memory access.
//   allocate: a left-first search over the nodes, a split per level, the
//     used mark, then the ancestors marked full.
//   free: a walk down the levels, buddies merged, then the ancestors turned
//     back to split.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds the block only once a second result is
// ready. Reset gives 128 leaves of 16 bytes, all free. A write of
// tree_levels (APB, address 0) empties the tree at once by clearing the
// per-node valid flags; no clearing pass is needed.
`default_nettype none
module buddy_block_allocator
  import bba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire req_t        in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rsp_t             out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_CHK = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_P_RD  = 4'd4;
  localparam logic [3:0] S_P_CHK = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_CHK = 4'd7;
  localparam logic [3:0] S_M_RD  = 4'd8;
  localparam logic [3:0] S_M_CHK = 4'd9;
  localparam logic [3:0] S_M_WR  = 4'd10;
  localparam logic [3:0] S_U_RD  = 4'd11;
  localparam logic [3:0] S_U_CHK = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  function automatic logic [NODE_AW-1:0] node_at(logic [LVL_W-1:0] l, logic [POS_W-1:0] p);
    return ((NODE_AW'(1) << l) - NODE_AW'(1)) + NODE_AW'(p);
  endfunction

  function automatic logic [NODE_AW-1:0] sib(logic [NODE_AW-1:0] i);
    return i[0] ? i + NODE_AW'(1) : i - NODE_AW'(1);
  endfunction

  function automatic logic [NODE_AW-1:0] parent(logic [NODE_AW-1:0] i);
    return (i - NODE_AW'(1)) >> 1;
  endfunction

  function automatic logic [3:0] bit_len(logic [7:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 4'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] trail_z(logic [NODE_AW-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = NODE_AW - 2; i >= 0; i--) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  logic [3:0]            state_q, state_d;
  logic [LVL_W-1:0]      levels_q, levels_d;
  logic [11:0]           free_q, free_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [LVL_W-1:0]      lv_q, lv_d;
  logic [LVL_W-1:0]      k_q, k_d;
  logic [11:0]           blk_q, blk_d;
  logic [POS_W-1:0]      tpos_q, tpos_d;
  logic                  sub_q, sub_d;
  logic [NODE_AW-1:0]    idx_q, idx_d;
  logic [11:0]           start_q, start_d;
  logic [11:0]           len_q, len_d;
  logic [10:0]           off_q, off_d;
  logic [1:0]            st_q, st_d;
  logic [10:0]           aoff_q, aoff_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;
  logic [NODE_COUNT-1:0] vld_q, vld_d;
  logic                  rd_vld_q;

  logic                  we, re;
  logic [NODE_AW-1:0]    waddr, raddr;
  logic [1:0]            wdata, rdata, node_st;
  logic                  cfg_wr;
  logic [11:0]           total;
  logic [11:0]           sm1;
  logic [3:0]            k_need;
  logic [12:0]           blk13;
  logic [NODE_AW-1:0]    np;
  logic [LVL_W-1:0]      tz;
  logic [11:0]           half;
  logic [12:0]           sum13;

  bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign node_st    = rd_vld_q ? rdata : ND_FREE;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_TREE_LEVELS);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_TREE_LEVELS) ? 32'(levels_q) : 32'd0;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign total = 12'(LEAF_BYTES) << levels_q;

  assign sm1    = in_data_i.request_size - 12'd1;
  assign k_need = bit_len(sm1[11:4]);
  assign blk13  = 13'(LEAF_BYTES) << k_need;
  assign np     = {1'b0, pos_q} + NODE_AW'(1);
  assign tz     = trail_z(np);
  assign half   = len_q >> 1;
  assign sum13  = {1'b0, free_q} + {1'b0, len_q};

  always_comb begin
    state_d = state_q;   levels_d = levels_q; free_d = free_q;
    lvl_d = lvl_q;       pos_d = pos_q;       lv_d = lv_q;
    k_d = k_q;           blk_d = blk_q;       tpos_d = tpos_q;
    sub_d = sub_q;       idx_d = idx_q;       start_d = start_q;
    len_d = len_q;       off_d = off_q;       st_d = st_q;
    aoff_d = aoff_q;     out_valid_d = out_valid_q;
    out_d = out_q;       vld_d = vld_q;
    we = 1'b0; waddr = '0; wdata = ND_FREE;
    re = 1'b0; raddr = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          aoff_d = '0;
          if (in_data_i.mode) begin
            off_d = in_data_i.block_offset;
            idx_d = '0; start_d = '0; len_d = total; lvl_d = '0;
            state_d = S_F_RD;
          end else if (in_data_i.request_size == 12'd0) begin
            st_d = RS_ZERO; state_d = S_DONE;
          end else if (k_need > 4'(levels_q) || blk13 > {1'b0, free_q}) begin
            st_d = RS_NO_SPACE; state_d = S_DONE;
          end else begin
            k_d = LVL_W'(k_need);
            blk_d = blk13[11:0];
            lv_d = levels_q - LVL_W'(k_need);
            lvl_d = '0; pos_d = '0;
            state_d = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        re = 1'b1; raddr = node_at(lvl_q, pos_q);
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (node_st == ND_FREE) begin
          tpos_d = pos_q << (lv_q - lvl_q);
          sub_d = 1'b0;
          state_d = S_SPLIT;
        end else if (lvl_q == lv_q || node_st != ND_SPLIT) begin
          // skip the whole subtree and resume at the next unvisited node
          if (np == (NODE_AW'(1) << lvl_q)) begin
            st_d = RS_NO_SPACE; state_d = S_DONE;
          end else begin
            lvl_d = lvl_q - tz;
            pos_d = POS_W'(np >> tz);
            state_d = S_A_RD;
          end
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
          pos_d = pos_q << 1;
          state_d = S_A_RD;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (lvl_q == lv_q) begin
          waddr = node_at(lv_q, tpos_q); wdata = ND_USED;
          idx_d = node_at(lv_q, tpos_q);
          free_d = free_q - blk_q;
          aoff_d = 11'({tpos_q, 4'b0000} << k_q);
          state_d = S_P_RD;
        end else if (!sub_q) begin
          waddr = node_at(lvl_q, tpos_q >> (lv_q - lvl_q)); wdata = ND_SPLIT;
          sub_d = 1'b1;
        end else begin
          waddr = sib(node_at(lvl_q + LVL_W'(1),
                              tpos_q >> (lv_q - lvl_q - LVL_W'(1))));
          wdata = ND_FREE;
          sub_d = 1'b0;
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_P_RD: begin
        if (idx_q == '0) begin
          st_d = RS_OK; state_d = S_DONE;
        end else begin
          re = 1'b1; raddr = sib(idx_q);
          state_d = S_P_CHK;
        end
      end
      S_P_CHK: begin
        if (node_st == ND_USED || node_st == ND_FULL) begin
          we = 1'b1; waddr = parent(idx_q); wdata = ND_FULL;
          idx_d = parent(idx_q);
          state_d = S_P_RD;
        end else begin
          st_d = RS_OK; state_d = S_DONE;
        end
      end
      S_F_RD: begin
        re = 1'b1; raddr = idx_q;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (node_st == ND_USED) begin
          if ({1'b0, off_q} != start_q) begin
            st_d = RS_BAD_OFFS; state_d = S_DONE;
          end else begin
            free_d = (sum13 > {1'b0, total}) ? total : sum13[11:0];
            state_d = S_M_RD;
          end
        end else if (node_st == ND_FREE || lvl_q >= levels_q) begin
          st_d = RS_BAD_OFFS; state_d = S_DONE;
        end else begin
          len_d = half;
          lvl_d = lvl_q + LVL_W'(1);
          if ({1'b0, off_q} < start_q + half) begin
            idx_d = {idx_q[NODE_AW-2:0], 1'b1};
          end else begin
            idx_d = {idx_q[NODE_AW-2:0], 1'b0} + NODE_AW'(2);
            start_d = start_q + half;
          end
          state_d = S_F_RD;
        end
      end
      S_M_RD: begin
        if (idx_q == '0) begin
          state_d = S_M_WR;
        end else begin
          re = 1'b1; raddr = sib(idx_q);
          state_d = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if (node_st == ND_FREE) begin
          idx_d = parent(idx_q);
          state_d = S_M_RD;
        end else begin
          state_d = S_M_WR;
        end
      end
      S_M_WR: begin
        we = 1'b1; waddr = idx_q; wdata = ND_FREE;
        state_d = S_U_RD;
      end
      S_U_RD: begin
        if (idx_q == '0) begin
          st_d = RS_OK; state_d = S_DONE;
        end else begin
          re = 1'b1; raddr = parent(idx_q);
          idx_d = parent(idx_q);
          state_d = S_U_CHK;
        end
      end
      S_U_CHK: begin
        if (node_st == ND_FULL) begin
          we = 1'b1; waddr = idx_q; wdata = ND_SPLIT;
          state_d = S_U_RD;
        end else begin
          st_d = RS_OK; state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.status = st_q;
          out_d.alloc_offset = aoff_q;
          out_d.remaining_bytes = free_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (we) begin
      vld_d[waddr] = 1'b1;
    end
    if (cfg_wr) begin
      // empty the tree and take the new size
      levels_d = pwdata[LVL_W-1:0];
      free_d = 12'(LEAF_BYTES) << pwdata[LVL_W-1:0];
      vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      levels_q    <= LVL_W'(MAX_LEVELS);
      free_q      <= 12'(LEAF_BYTES) << MAX_LEVELS;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      levels_q    <= levels_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      if (re) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;   pos_q   <= pos_d;   lv_q    <= lv_d;
    k_q     <= k_d;     blk_q   <= blk_d;   tpos_q  <= tpos_d;
    sub_q   <= sub_d;   idx_q   <= idx_d;   start_q <= start_d;
    len_q   <= len_d;   off_q   <= off_d;   st_q    <= st_d;
    aoff_q  <= aoff_d;  out_q   <= out_d;
  end

endmodule
`default_nettype wire

// ----- rtl/bba_checker.sv -----
// Port-level checker for the buddy block allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bba_checker
  import bba_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire req_t        in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire rsp_t        out_data_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  logic unused_ok;
  assign unused_ok = ^{in_valid_i, in_ready_o, in_data_i, psel, penable, pwrite,
                       paddr, pwdata, prdata};

  // a stalled result word holds
  `BBA_ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `BBA_ASSERT_STD(a_free_max, out_valid_o |-> out_data_o.remaining_bytes <= 12'd2048)
  `BBA_ASSERT_STD(a_fail_offs, out_valid_o && out_data_o.status != RS_OK |-> out_data_o.alloc_offset == 11'd0)
  `BBA_ASSERT_STD(a_offs_align, out_valid_o |-> out_data_o.alloc_offset[3:0] == 4'd0)
  `BBA_ASSERT_STD(a_pready, pready)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire
